// File: hw/rtl/gcs_pkg.sv
// Shared types, codes and calendar tables for the Gregorian calendar stepper.
package gcs_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int STAT_W  = 2;
    localparam int ACT_W   = 3;
    localparam int CENT_W  = 8;
    localparam int YY_W    = 7;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // Division by 100 of a 14-bit year: q = (y * DIV100_MUL) >> DIV100_SHIFT.
    localparam int DIV100_MUL_W  = 13;
    localparam int DIV100_SHIFT  = 19;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;

    typedef logic [ACT_W-1:0]   action_t;
    typedef logic [STAT_W-1:0]  status_t;
    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [WDAY_W-1:0]  wday_t;
    typedef logic [CENT_W-1:0]  cent_t;
    typedef logic [YY_W-1:0]    yy_t;

    localparam action_t ACT_QUERY      = 3'd0;
    localparam action_t ACT_LOAD       = 3'd1;
    localparam action_t ACT_NEXT_DAY   = 3'd2;
    localparam action_t ACT_PREV_DAY   = 3'd3;
    localparam action_t ACT_NEXT_MONTH = 3'd4;
    localparam action_t ACT_PREV_MONTH = 3'd5;
    localparam action_t ACT_NEXT_YEAR  = 3'd6;
    localparam action_t ACT_PREV_YEAR  = 3'd7;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_BADLOAD = 2'd1;
    localparam status_t STATUS_RANGE   = 2'd2;

    localparam month_t MONTH_JAN = 4'd1;
    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_DEC = 4'd12;
    localparam day_t   DAY_FIRST = 5'd1;
    localparam day_t   DAY_28    = 5'd28;
    localparam day_t   DAY_29    = 5'd29;
    localparam day_t   DAY_31    = 5'd31;
    localparam yy_t    YY_LAST   = 7'd99;

    function automatic logic is_leap(cent_t cent, yy_t yy);
        logic r;
        if (yy != '0) begin
            r = (yy[1:0] == 2'd0);
        end else begin
            r = (cent[1:0] == 2'd0);
        end
        return r;
    endfunction

    function automatic day_t last_day(logic leap, month_t m);
        day_t r;
        unique case (m)
            4'd2:                      r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] month_off(logic leap, month_t m);
        logic [2:0] r;
        unique case (m)
            4'd2:    r = leap ? 3'd2 : 3'd3;
            4'd3:    r = 3'd3;
            4'd4:    r = 3'd6;
            4'd5:    r = 3'd1;
            4'd6:    r = 3'd4;
            4'd7:    r = 3'd6;
            4'd8:    r = 3'd2;
            4'd9:    r = 3'd5;
            4'd10:   r = 3'd0;
            4'd11:   r = 3'd3;
            4'd12:   r = 3'd5;
            default: r = leap ? 3'd6 : 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] century_off(cent_t cent);
        logic [2:0] idx;
        logic [2:0] r;
        idx = cent[2:0] + 3'd7;
        unique case (idx[1:0])
            2'd0:    r = 3'd4;
            2'd1:    r = 3'd2;
            2'd2:    r = 3'd0;
            default: r = 3'd6;
        endcase
        return r;
    endfunction

    // Since 8 is 1 modulo 7, folding the high bits onto the low three keeps the residue.
    function automatic wday_t weekday(cent_t cent, yy_t yy, month_t m, day_t d, logic leap);
        logic [7:0] sum;
        logic [5:0] f1;
        logic [3:0] f2;
        wday_t      r;
        sum = 8'(century_off(cent)) + 8'(yy) + 8'(yy[YY_W-1:2]) + 8'(d)
            + 8'(month_off(leap, m));
        f1 = 6'(sum[7:3]) + 6'(sum[2:0]);
        f2 = 4'(f1[5:3]) + 4'(f1[2:0]);
        if (f2 >= 4'd7) begin
            r = 3'(f2 - 4'd7);
        end else begin
            r = 3'(f2);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/gregorian_calendar_stepper.sv
// Top level of the Gregorian calendar stepper: command register, date update and result register.
// An accepted beat passes through the command register and then the result register.
// Throughput: one beat per cycle while the output is not stalled; the held date is updated in
// the same edge that loads the result register, so the next command already sees it.
// Reset: synchronous on aresetn low; the date returns to 1 January of YEAR_LOW
// and both pipeline registers are emptied.
module gregorian_calendar_stepper #(
    parameter int YEAR_LOW  = 1753,
    parameter int YEAR_HIGH = 9999
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action[2:0], load_year[16:3], load_month[20:17], load_day[25:21]
    input  logic [gcs_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cur_year[13:0], cur_month[17:14], cur_day[22:18], weekday[25:23], leap[26],
    // status[28:27]
    output logic [gcs_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam gcs_pkg::year_t Y_LOW  = gcs_pkg::year_t'(YEAR_LOW);
    localparam gcs_pkg::year_t Y_HIGH = gcs_pkg::year_t'(YEAR_HIGH);
    localparam gcs_pkg::cent_t C_LOW  = gcs_pkg::cent_t'(YEAR_LOW / 100);
    localparam gcs_pkg::yy_t   YY_LOW = gcs_pkg::yy_t'(YEAR_LOW % 100);

    // Incoming beat fields.
    gcs_pkg::action_t s_action;
    gcs_pkg::year_t   s_year;
    gcs_pkg::month_t  s_month;
    gcs_pkg::day_t    s_day;

    assign s_action = s_tdata[2:0];
    assign s_year   = s_tdata[16:3];
    assign s_month  = s_tdata[20:17];
    assign s_day    = s_tdata[25:21];

    // Load year split into century and year of century, and the load check.
    logic [gcs_pkg::YEAR_W+gcs_pkg::DIV100_MUL_W-1:0] s_prod;
    gcs_pkg::cent_t s_cent;
    gcs_pkg::year_t s_rem;
    gcs_pkg::yy_t   s_yy;
    logic           s_leap;
    logic           s_ok;

    always_comb begin
        s_prod = (gcs_pkg::YEAR_W + gcs_pkg::DIV100_MUL_W)'(s_year)
               * (gcs_pkg::YEAR_W + gcs_pkg::DIV100_MUL_W)'(gcs_pkg::DIV100_MUL);
        s_cent = s_prod[gcs_pkg::DIV100_SHIFT +: gcs_pkg::CENT_W];
        s_rem  = s_year - gcs_pkg::year_t'(s_cent) * gcs_pkg::year_t'(100);
        s_yy   = s_rem[gcs_pkg::YY_W-1:0];
        s_leap = gcs_pkg::is_leap(s_cent, s_yy);
        s_ok   = (s_year >= Y_LOW) && (s_year <= Y_HIGH)
              && (s_month >= gcs_pkg::MONTH_JAN) && (s_month <= gcs_pkg::MONTH_DEC)
              && (s_day >= gcs_pkg::DAY_FIRST)
              && (s_day <= gcs_pkg::last_day(s_leap, s_month));
    end

    // Command register.
    logic             in_valid_reg;
    gcs_pkg::action_t in_action_reg;
    gcs_pkg::year_t   in_year_reg;
    gcs_pkg::month_t  in_month_reg;
    gcs_pkg::day_t    in_day_reg;
    gcs_pkg::cent_t   in_cent_reg;
    gcs_pkg::yy_t     in_yy_reg;
    logic             in_ok_reg;

    // Held date, kept also as century and year of century.
    gcs_pkg::year_t   year_reg,  year_next;
    gcs_pkg::month_t  month_reg, month_next;
    gcs_pkg::day_t    day_reg,   day_next;
    gcs_pkg::cent_t   cent_reg,  cent_next;
    gcs_pkg::yy_t     yy_reg,    yy_next;

    // Result register.
    logic             out_valid_reg;
    gcs_pkg::wday_t   wday_reg,   wday_next;
    logic             leap_reg,   leap_next;
    gcs_pkg::status_t status_reg, status_next;

    logic advance;
    logic s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= s_action;
            in_year_reg   <= s_year;
            in_month_reg  <= s_month;
            in_day_reg    <= s_day;
            in_cent_reg   <= s_cent;
            in_yy_reg     <= s_yy;
            in_ok_reg     <= s_ok;
        end
    end

    // Neighbors of the held year.
    gcs_pkg::cent_t cent_inc, cent_dec;
    gcs_pkg::yy_t   yy_inc,   yy_dec;
    logic           leap_cur, leap_inc, leap_dec;
    gcs_pkg::day_t  last_cur;

    always_comb begin
        if (yy_reg == gcs_pkg::YY_LAST) begin
            yy_inc   = '0;
            cent_inc = cent_reg + 1'b1;
        end else begin
            yy_inc   = yy_reg + 1'b1;
            cent_inc = cent_reg;
        end
        if (yy_reg == '0) begin
            yy_dec   = gcs_pkg::YY_LAST;
            cent_dec = cent_reg - 1'b1;
        end else begin
            yy_dec   = yy_reg - 1'b1;
            cent_dec = cent_reg;
        end
        leap_cur = gcs_pkg::is_leap(cent_reg, yy_reg);
        leap_inc = gcs_pkg::is_leap(cent_inc, yy_inc);
        leap_dec = gcs_pkg::is_leap(cent_dec, yy_dec);
        last_cur = gcs_pkg::last_day(leap_cur, month_reg);
    end

    always_comb begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        cent_next   = cent_reg;
        yy_next     = yy_reg;
        status_next = gcs_pkg::STATUS_OK;
        unique case (in_action_reg)
            gcs_pkg::ACT_LOAD: begin
                if (in_ok_reg) begin
                    year_next  = in_year_reg;
                    month_next = in_month_reg;
                    day_next   = in_day_reg;
                    cent_next  = in_cent_reg;
                    yy_next    = in_yy_reg;
                end else begin
                    status_next = gcs_pkg::STATUS_BADLOAD;
                end
            end
            gcs_pkg::ACT_NEXT_DAY: begin
                if (day_reg < last_cur) begin
                    day_next = day_reg + 1'b1;
                end else if (month_reg < gcs_pkg::MONTH_DEC) begin
                    month_next = month_reg + 1'b1;
                    day_next   = gcs_pkg::DAY_FIRST;
                end else if (year_reg < Y_HIGH) begin
                    year_next  = year_reg + 1'b1;
                    cent_next  = cent_inc;
                    yy_next    = yy_inc;
                    month_next = gcs_pkg::MONTH_JAN;
                    day_next   = gcs_pkg::DAY_FIRST;
                end else begin
                    status_next = gcs_pkg::STATUS_RANGE;
                end
            end
            gcs_pkg::ACT_PREV_DAY: begin
                if (day_reg > gcs_pkg::DAY_FIRST) begin
                    day_next = day_reg - 1'b1;
                end else if (month_reg > gcs_pkg::MONTH_JAN) begin
                    month_next = month_reg - 1'b1;
                    day_next   = gcs_pkg::last_day(leap_cur, month_reg - 1'b1);
                end else if (year_reg > Y_LOW) begin
                    year_next  = year_reg - 1'b1;
                    cent_next  = cent_dec;
                    yy_next    = yy_dec;
                    month_next = gcs_pkg::MONTH_DEC;
                    day_next   = gcs_pkg::DAY_31;
                end else begin
                    status_next = gcs_pkg::STATUS_RANGE;
                end
            end
            gcs_pkg::ACT_NEXT_MONTH: begin
                if (month_reg < gcs_pkg::MONTH_DEC) begin
                    month_next = month_reg + 1'b1;
                    if (day_reg > gcs_pkg::last_day(leap_cur, month_reg + 1'b1)) begin
                        day_next = gcs_pkg::last_day(leap_cur, month_reg + 1'b1);
                    end
                end else if (year_reg < Y_HIGH) begin
                    year_next  = year_reg + 1'b1;
                    cent_next  = cent_inc;
                    yy_next    = yy_inc;
                    month_next = gcs_pkg::MONTH_JAN;
                end else begin
                    status_next = gcs_pkg::STATUS_RANGE;
                end
            end
            gcs_pkg::ACT_PREV_MONTH: begin
                if (month_reg > gcs_pkg::MONTH_JAN) begin
                    month_next = month_reg - 1'b1;
                    if (day_reg > gcs_pkg::last_day(leap_cur, month_reg - 1'b1)) begin
                        day_next = gcs_pkg::last_day(leap_cur, month_reg - 1'b1);
                    end
                end else if (year_reg > Y_LOW) begin
                    year_next  = year_reg - 1'b1;
                    cent_next  = cent_dec;
                    yy_next    = yy_dec;
                    month_next = gcs_pkg::MONTH_DEC;
                end else begin
                    status_next = gcs_pkg::STATUS_RANGE;
                end
            end
            gcs_pkg::ACT_NEXT_YEAR: begin
                if (year_reg < Y_HIGH) begin
                    year_next = year_reg + 1'b1;
                    cent_next = cent_inc;
                    yy_next   = yy_inc;
                    if (month_reg == gcs_pkg::MONTH_FEB && day_reg == gcs_pkg::DAY_29
                        && !leap_inc) begin
                        day_next = gcs_pkg::DAY_28;
                    end
                end else begin
                    status_next = gcs_pkg::STATUS_RANGE;
                end
            end
            gcs_pkg::ACT_PREV_YEAR: begin
                if (year_reg > Y_LOW) begin
                    year_next = year_reg - 1'b1;
                    cent_next = cent_dec;
                    yy_next   = yy_dec;
                    if (month_reg == gcs_pkg::MONTH_FEB && day_reg == gcs_pkg::DAY_29
                        && !leap_dec) begin
                        day_next = gcs_pkg::DAY_28;
                    end
                end else begin
                    status_next = gcs_pkg::STATUS_RANGE;
                end
            end
            default: begin
            end
        endcase
        leap_next = gcs_pkg::is_leap(cent_next, yy_next);
        wday_next = gcs_pkg::weekday(cent_next, yy_next, month_next, day_next, leap_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_reg      <= Y_LOW;
            month_reg     <= gcs_pkg::MONTH_JAN;
            day_reg       <= gcs_pkg::DAY_FIRST;
            cent_reg      <= C_LOW;
            yy_reg        <= YY_LOW;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                year_reg  <= year_next;
                month_reg <= month_next;
                day_reg   <= day_next;
                cent_reg  <= cent_next;
                yy_reg    <= yy_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            wday_reg   <= wday_next;
            leap_reg   <= leap_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, status_reg, leap_reg, wday_reg, day_reg, month_reg, year_reg};

endmodule

// File: hw/rtl/gcs_checker.sv
// Port-level checker for the Gregorian calendar stepper and its bind statement.
module gcs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [gcs_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gcs_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [gcs_pkg::STAT_W-1:0] m_status;
    assign m_status = m_tdata[28:27];

    // The result register is empty the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // With no result pending, the block must always take a new beat.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

    // A stalled result beat holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Every delivered date has a month in range, a nonzero day and a weekday below 7, and the status is a defined code.
    a_date_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:14] >= gcs_pkg::MONTH_JAN)
                  && (m_tdata[17:14] <= gcs_pkg::MONTH_DEC)
                  && (m_tdata[22:18] >= gcs_pkg::DAY_FIRST)
                  && (m_tdata[25:23] != 3'd7)
                  && (m_status == gcs_pkg::STATUS_OK || m_status == gcs_pkg::STATUS_BADLOAD
                      || m_status == gcs_pkg::STATUS_RANGE))
        else $error("malformed result beat");

endmodule

bind gregorian_calendar_stepper gcs_checker u_gcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for the Gregorian calendar stepper with a date-stepping predictor.
module testbench;

    localparam int FIRST_YEAR = 1753;
    localparam int LAST_YEAR = 9999;
    localparam int PHASES = 4;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int DRAIN_CYCLES = 2000;
    localparam int IDLE_TAB[PHASES] = '{0, 64, 0, 26};
    localparam int STALL_TAB[PHASES] = '{0, 0, 64, 26};

    typedef struct {
        gcs_pkg::action_t act;
        gcs_pkg::year_t   ly;
        gcs_pkg::month_t  lm;
        gcs_pkg::day_t    ld;
    } calendar_cmd_t;

    typedef struct {
        gcs_pkg::year_t   year;
        gcs_pkg::month_t  month;
        gcs_pkg::day_t    day;
        gcs_pkg::wday_t   wday;
        logic             leap;
        gcs_pkg::status_t status;
    } date_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [gcs_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [gcs_pkg::M_TDATA_W-1:0] m_tdata;

    calendar_cmd_t cmd_queue[$];
    date_report_t  expected_dates[$];
    calendar_cmd_t shown_cmd;

    int held_year = FIRST_YEAR;
    int held_month = 1;
    int held_day = 1;

    int idle_pct = 0;
    int stall_pct = 0;
    int queued_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int badload_count = 0;
    int range_count = 0;
    int error_count = 0;

    gregorian_calendar_stepper #(
        .YEAR_LOW  (FIRST_YEAR),
        .YEAR_HIGH (LAST_YEAR)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int y, int m);
        int n;
        case (m)
            2:             n = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    function automatic int day_of_week(int y, int m, int d);
        int yy;
        int cent;
        int mon;
        logic lp;
        yy = y % 100;
        lp = leap_year(y);
        case (((y / 100) + 7) % 8)
            0, 4:    cent = 4;
            1, 5:    cent = 2;
            2, 6:    cent = 0;
            default: cent = 6;
        endcase
        case (m)
            2:       mon = lp ? 2 : 3;
            3:       mon = 3;
            4:       mon = 6;
            5:       mon = 1;
            6:       mon = 4;
            7:       mon = 6;
            8:       mon = 2;
            9:       mon = 5;
            10:      mon = 0;
            11:      mon = 3;
            12:      mon = 5;
            default: mon = lp ? 6 : 0;
        endcase
        return (cent + yy + yy / 4 + d + mon) % 7;
    endfunction

    function automatic date_report_t step_held_date(calendar_cmd_t c);
        int y;
        int m;
        int d;
        gcs_pkg::status_t st;
        date_report_t r;
        y = held_year;
        m = held_month;
        d = held_day;
        st = gcs_pkg::STATUS_OK;
        case (c.act)
            gcs_pkg::ACT_LOAD: begin
                if (int'(c.ly) >= FIRST_YEAR && int'(c.ly) <= LAST_YEAR && c.lm >= 1
                        && c.lm <= 12 && c.ld >= 1
                        && int'(c.ld) <= month_days(int'(c.ly), int'(c.lm))) begin
                    y = int'(c.ly);
                    m = int'(c.lm);
                    d = int'(c.ld);
                end else begin
                    st = gcs_pkg::STATUS_BADLOAD;
                end
            end
            gcs_pkg::ACT_NEXT_DAY: begin
                if (d < month_days(y, m)) begin
                    d++;
                end else if (m < 12) begin
                    m++;
                    d = 1;
                end else if (y < LAST_YEAR) begin
                    y++;
                    m = 1;
                    d = 1;
                end else begin
                    st = gcs_pkg::STATUS_RANGE;
                end
            end
            gcs_pkg::ACT_PREV_DAY: begin
                if (d > 1) begin
                    d--;
                end else if (m > 1) begin
                    m--;
                    d = month_days(y, m);
                end else if (y > FIRST_YEAR) begin
                    y--;
                    m = 12;
                    d = 31;
                end else begin
                    st = gcs_pkg::STATUS_RANGE;
                end
            end
            gcs_pkg::ACT_NEXT_MONTH, gcs_pkg::ACT_PREV_MONTH: begin
                if (c.act == gcs_pkg::ACT_NEXT_MONTH) begin
                    if (m < 12) m++;
                    else if (y < LAST_YEAR) begin
                        y++;
                        m = 1;
                    end else st = gcs_pkg::STATUS_RANGE;
                end else begin
                    if (m > 1) m--;
                    else if (y > FIRST_YEAR) begin
                        y--;
                        m = 12;
                    end else st = gcs_pkg::STATUS_RANGE;
                end
                if (st == gcs_pkg::STATUS_OK && d > month_days(y, m)) d = month_days(y, m);
            end
            gcs_pkg::ACT_NEXT_YEAR, gcs_pkg::ACT_PREV_YEAR: begin
                if (c.act == gcs_pkg::ACT_NEXT_YEAR) begin
                    if (y < LAST_YEAR) y++;
                    else st = gcs_pkg::STATUS_RANGE;
                end else begin
                    if (y > FIRST_YEAR) y--;
                    else st = gcs_pkg::STATUS_RANGE;
                end
                if (st == gcs_pkg::STATUS_OK && m == 2 && d == 29 && !leap_year(y)) d = 28;
            end
            default: begin
            end
        endcase
        if (st == gcs_pkg::STATUS_OK) begin
            held_year = y;
            held_month = m;
            held_day = d;
        end
        r.year = gcs_pkg::year_t'(held_year);
        r.month = gcs_pkg::month_t'(held_month);
        r.day = gcs_pkg::day_t'(held_day);
        r.wday = gcs_pkg::wday_t'(day_of_week(held_year, held_month, held_day));
        r.leap = leap_year(held_year);
        r.status = st;
        return r;
    endfunction

    task automatic push_cmd(gcs_pkg::action_t a, int y, int m, int d);
        calendar_cmd_t c;
        c.act = a;
        c.ly = gcs_pkg::year_t'(y);
        c.lm = gcs_pkg::month_t'(m);
        c.ld = gcs_pkg::day_t'(d);
        cmd_queue.push_back(c);
        queued_count++;
    endtask

    task automatic push_noisy_cmd(gcs_pkg::action_t a);
        push_cmd(a, $urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
    endtask

    task automatic push_valid_load();
        int y;
        int m;
        int last;
        case ($urandom_range(0, 4))
            0:       y = $urandom_range(FIRST_YEAR, FIRST_YEAR + 3);
            1:       y = $urandom_range(LAST_YEAR - 3, LAST_YEAR);
            2:       y = $urandom_range(18, 99) * 100 - $urandom_range(0, 4);
            default: y = $urandom_range(FIRST_YEAR, LAST_YEAR);
        endcase
        m = $urandom_range(1, 12);
        last = month_days(y, m);
        push_cmd(gcs_pkg::ACT_LOAD, y, m, $urandom_range(0, 1) ? last : $urandom_range(1, last));
    endtask

    task automatic queue_random_cmds(int n);
        int target;
        int steps;
        gcs_pkg::action_t a;
        target = queued_count + n;
        while (queued_count < target) begin
            case ($urandom_range(0, 99)) inside
                [0:7]:   push_noisy_cmd(gcs_pkg::ACT_LOAD);
                [8:11]:  push_noisy_cmd(gcs_pkg::ACT_QUERY);
                default: begin
                    push_valid_load();
                    steps = $urandom_range(1, 16);
                    a = gcs_pkg::action_t'($urandom_range(gcs_pkg::ACT_NEXT_DAY,
                                                          gcs_pkg::ACT_PREV_YEAR));
                    repeat (steps) begin
                        if ($urandom_range(0, 2) == 0) begin
                            a = gcs_pkg::action_t'($urandom_range(gcs_pkg::ACT_NEXT_DAY,
                                                                  gcs_pkg::ACT_PREV_YEAR));
                        end
                        push_noisy_cmd(a);
                    end
                end
            endcase
        end
    endtask

    task automatic queue_directed_cmds();
        push_cmd(gcs_pkg::ACT_QUERY, 16383, 15, 31);
        push_cmd(gcs_pkg::ACT_PREV_DAY, 0, 0, 0);
        push_cmd(gcs_pkg::ACT_PREV_MONTH, 0, 0, 0);
        push_cmd(gcs_pkg::ACT_PREV_YEAR, 16383, 15, 31);
        push_cmd(gcs_pkg::ACT_LOAD, FIRST_YEAR - 1, 12, 31);
        push_cmd(gcs_pkg::ACT_LOAD, 16383, 15, 31);
        push_cmd(gcs_pkg::ACT_LOAD, 0, 0, 0);
        push_cmd(gcs_pkg::ACT_LOAD, LAST_YEAR + 1, 1, 1);
        push_cmd(gcs_pkg::ACT_LOAD, 2023, 13, 1);
        push_cmd(gcs_pkg::ACT_LOAD, 2023, 4, 31);
        push_cmd(gcs_pkg::ACT_LOAD, 1900, 2, 29);
        push_cmd(gcs_pkg::ACT_LOAD, 2000, 2, 29);
        push_cmd(gcs_pkg::ACT_NEXT_YEAR, 0, 0, 0);
        push_cmd(gcs_pkg::ACT_LOAD, 2004, 2, 29);
        push_cmd(gcs_pkg::ACT_PREV_YEAR, 0, 0, 0);
        push_cmd(gcs_pkg::ACT_LOAD, 2001, 1, 31);
        push_cmd(gcs_pkg::ACT_NEXT_MONTH, 0, 0, 0);
        push_cmd(gcs_pkg::ACT_LOAD, 2000, 3, 1);
        push_cmd(gcs_pkg::ACT_PREV_DAY, 0, 0, 0);
        push_cmd(gcs_pkg::ACT_LOAD, LAST_YEAR, 12, 31);
        push_cmd(gcs_pkg::ACT_NEXT_DAY, 0, 0, 0);
        push_cmd(gcs_pkg::ACT_NEXT_MONTH, 0, 0, 0);
        push_cmd(gcs_pkg::ACT_NEXT_YEAR, 0, 0, 0);
        push_cmd(gcs_pkg::ACT_PREV_MONTH, 0, 0, 0);
        push_cmd(gcs_pkg::ACT_LOAD, FIRST_YEAR, 12, 31);
        push_cmd(gcs_pkg::ACT_NEXT_DAY, 0, 0, 0);
    endtask

    // The sender stays quiet until every predicted result has been returned or the drain wait runs out.
    task automatic drain_results();
        int waited;
        wait (accepted_count == queued_count);
        waited = 0;
        while (expected_dates.size() > 0 && waited < DRAIN_CYCLES) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
    endtask

    function automatic void check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_dates.push_back(step_held_date(shown_cmd));
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    shown_cmd = cmd_queue.pop_front();
                    s_tdata <= {6'd0, shown_cmd.ld, shown_cmd.lm, shown_cmd.ly, shown_cmd.act};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        date_report_t exp_rep;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_dates.size() == 0) begin
                $error("result beat 0x%08h arrived with no result expected", m_tdata);
                error_count++;
            end else begin
                exp_rep = expected_dates.pop_front();
                check_field("cur_year", exp_rep.year, m_tdata[13:0]);
                check_field("cur_month", exp_rep.month, m_tdata[17:14]);
                check_field("cur_day", exp_rep.day, m_tdata[22:18]);
                check_field("weekday", exp_rep.wday, m_tdata[25:23]);
                check_field("leap", exp_rep.leap, m_tdata[26]);
                check_field("status", exp_rep.status, m_tdata[28:27]);
                if (exp_rep.status == gcs_pkg::STATUS_BADLOAD) badload_count++;
                if (exp_rep.status == gcs_pkg::STATUS_RANGE) range_count++;
                checked_count++;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        queue_directed_cmds();
        drain_results();
        for (int p = 0; p < PHASES; p++) begin
            idle_pct = IDLE_TAB[p];
            stall_pct = STALL_TAB[p];
            queue_random_cmds(RANDOM_PER_PHASE);
            drain_results();
        end
        if (expected_dates.size() != 0) begin
            $error("%0d expected results never arrived", expected_dates.size());
            error_count++;
        end
        $display("Stepped through %0d calendar commands over %0d idle and stall settings.",
                 accepted_count, PHASES);
        $display("Checked %0d results, %0d rejected loads and %0d out-of-range steps.",
                 checked_count, badload_count, range_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
